FILE: rtl/core/char_lcd_command_interpreter_core_macros.svh
// assertion macros for the character lcd command interpreter
`ifndef CHAR_LCD_COMMAND_INTERPRETER_CORE_MACROS_SVH
`define CHAR_LCD_COMMAND_INTERPRETER_CORE_MACROS_SVH

// property checked on every clock edge out of reset
`define CLCI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("clci check failed");

// consequence checked in the cycle after the trigger
`define CLCI_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("clci check failed");

`endif

FILE: rtl/core/clci_pkg.sv
// shared types and constants of the character lcd command interpreter
package clci_pkg;

  typedef enum logic [2:0] {
    EV_CELL     = 3'd0,
    EV_REDRAW   = 3'd1,
    EV_GLYPH    = 3'd2,
    EV_CONTRAST = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_READ     = 3'd5
  } ev_e;

  typedef enum logic [1:0] {
    SEL_READ,
    SEL_REDRAW,
    SEL_CELL,
    SEL_EVENT
  } out_sel_e;

  localparam int unsigned CurRowW = 3;
  localparam int unsigned RowW    = 2;

  localparam logic [7:0] CH_CMD   = 8'd254;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_GLYPH_LIMIT = 8'd8;
  localparam logic [7:0] CH_Q     = "Q";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CH_B     = "B";
  localparam logic [7:0] CH_F     = "F";
  localparam logic [7:0] CH_X     = "X";
  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_L     = "L";
  localparam logic [7:0] CH_M     = "M";
  localparam logic [7:0] CH_N     = "N";
  localparam logic [7:0] CH_G     = "G";
  localparam logic [7:0] CH_HASH  = "#";

  // controller to datapath commands
  typedef struct packed {
    logic     latch;
    logic     exec;
    logic     rd_req;
    logic     cell_req;
    logic     scroll_start;
    logic     scroll_step;
    logic     scroll_end;
    logic     cell_write;
    logic     advance;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic mode_read;
    logic cmd_path;
    logic wrap;
    logic scroll_en;
    logic scroll_done;
    logic cell_change;
    logic ev_have;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/char_lcd_command_interpreter_core.sv
// top level of the serial command interpreter for a character lcd
// sequencing: one transfer at a time; the input stalls until the sequencer is idle again.
//   A scrolling wrap runs the scroll sweep, one read and one write per cycle, before the
//   redraw result.
// reset: asynchronous, active low; buffer reads as all spaces straight after reset
module char_lcd_command_interpreter_core #(
  parameter int unsigned COLUMNS = 20,
  parameter int unsigned ROWS    = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [7:0]                        data_byte_i,
  input  logic [((COLUMNS >= 32) ? 6 : 5)-1:0] read_column_i,
  input  logic [clci_pkg::RowW-1:0]         read_row_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        event_res_o,
  output logic [((COLUMNS >= 32) ? 6 : 5)-1:0] column_o,
  output logic [clci_pkg::RowW-1:0]         row_o,
  output logic [7:0]                        code_o,
  output logic [63:0]                       glyph_rows_o,
  output logic                              backlight_on_o,
  output logic [7:0]                        contrast_level_o,
  output logic                              last_o
);

  // column fields widen once the panel is 32 columns or more
  localparam int unsigned ColW = (COLUMNS >= 32) ? 6 : 5;

  clci_pkg::ctl_t ctl;
  clci_pkg::sts_t sts;

  // sequencer: one transfer at a time, waits on the result register
  clci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // buffer ram, cursor, command decode and the result register
  clci_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ColW    (ColW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .read_column_i    (read_column_i),
    .read_row_i       (read_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .column_o         (column_o),
    .row_o            (row_o),
    .code_o           (code_o),
    .glyph_rows_o     (glyph_rows_o),
    .backlight_on_o   (backlight_on_o),
    .contrast_level_o (contrast_level_o),
    .last_o           (last_o)
  );

endmodule

FILE: rtl/core/clci_ctrl.sv
// sequencing state machine of the command interpreter
module clci_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  clci_pkg::sts_t  sts_i,
  output clci_pkg::ctl_t  ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_OUT,
    S_CMD_OUT,
    S_SCROLL,
    S_CELL_REQ,
    S_CELL_CMP,
    S_REDRAW_OUT,
    S_CELL_OUT
  } state_e;

  state_e state_q, state_d;
  logic   redraw_q, redraw_d;
  logic   change_q, change_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    ctl_o    = '0;
    state_d  = state_q;
    redraw_d = redraw_q;
    change_d = change_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        redraw_d = 1'b0;
        priority if (sts_i.mode_read) begin
          ctl_o.rd_req = 1'b1;
          state_d      = S_RD_OUT;
        end else if (sts_i.cmd_path) begin
          ctl_o.exec = 1'b1;
          state_d    = S_CMD_OUT;
        end else if (sts_i.wrap) begin
          if (sts_i.scroll_en) begin
            ctl_o.scroll_start = 1'b1;
            redraw_d           = 1'b1;
            state_d            = S_SCROLL;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ctl_o.cell_req = 1'b1;
          state_d        = S_CELL_CMP;
        end
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = clci_pkg::SEL_READ;
          ctl_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CMD_OUT: begin
        if (!sts_i.ev_have) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = clci_pkg::SEL_EVENT;
          ctl_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (sts_i.scroll_done) begin
          ctl_o.scroll_end = 1'b1;
          state_d          = S_CELL_REQ;
        end else begin
          ctl_o.scroll_step = 1'b1;
        end
      end
      S_CELL_REQ: begin
        ctl_o.cell_req = 1'b1;
        state_d        = S_CELL_CMP;
      end
      S_CELL_CMP: begin
        change_d = sts_i.cell_change;
        if (redraw_q) begin
          state_d = S_REDRAW_OUT;
        end else if (sts_i.cell_change) begin
          state_d = S_CELL_OUT;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_REDRAW_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = clci_pkg::SEL_REDRAW;
          ctl_o.out_last = !change_q;
          if (change_q) begin
            state_d = S_CELL_OUT;
          end else begin
            ctl_o.advance = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      S_CELL_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load   = 1'b1;
          ctl_o.out_sel    = clci_pkg::SEL_CELL;
          ctl_o.out_last   = 1'b1;
          ctl_o.cell_write = 1'b1;
          ctl_o.advance    = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      redraw_q <= 1'b0;
      change_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      redraw_q <= redraw_d;
      change_q <= change_d;
    end
  end

endmodule

FILE: rtl/core/clci_dp.sv
// text buffer, cursor, command state and result register
module clci_dp #(
  parameter int unsigned COLUMNS = 20,
  parameter int unsigned ROWS    = 4,
  parameter int unsigned ColW    = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clci_pkg::ctl_t               ctl_i,
  output clci_pkg::sts_t               sts_o,
  input  logic                         mode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [ColW-1:0]              read_column_i,
  input  logic [clci_pkg::RowW-1:0]    read_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   event_res_o,
  output logic [ColW-1:0]              column_o,
  output logic [clci_pkg::RowW-1:0]    row_o,
  output logic [7:0]                   code_o,
  output logic [63:0]                  glyph_rows_o,
  output logic                         backlight_on_o,
  output logic [7:0]                   contrast_level_o,
  output logic                         last_o
);

  localparam int unsigned Cells    = COLUMNS * ROWS;
  localparam int unsigned AddrW    = $clog2(Cells);
  localparam int unsigned CntW     = $clog2(Cells + 1);
  localparam int unsigned ColIdxW  = $clog2(COLUMNS);
  localparam int unsigned SweepLen = (ROWS - 1) * COLUMNS;
  localparam int unsigned LastRow  = (ROWS - 1) * COLUMNS;
  localparam logic [AddrW:0]  ColsA    = (AddrW + 1)'(COLUMNS);
  localparam logic [CntW-1:0] SweepEnd = CntW'(SweepLen);
  localparam logic [CntW-1:0] ColsC    = CntW'(COLUMNS);

  typedef enum logic [2:0] {
    K_NONE,
    K_TIMEOUT,
    K_POSITION,
    K_CONTRAST,
    K_GLYPH,
    K_BIGNUM
  } kind_e;

  // latched input
  logic                       mode_q;
  logic [7:0]                 byte_q;
  logic [ColW-1:0]            rcol_q;
  logic [clci_pkg::RowW-1:0]  rrow_q;

  // buffer
  logic [7:0]       mem [Cells];
  logic [Cells-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             rd_vld_q;

  // cursor and command state
  logic [ColIdxW-1:0]          cur_col_q, cur_col_d;
  logic [clci_pkg::CurRowW-1:0] cur_row_q, cur_row_d;
  logic                        in_cmd_q, in_cmd_d;
  kind_e                       kind_q, kind_d;
  logic [3:0]                  step_q, step_d;
  logic                        scroll_q, scroll_d;
  logic                        bl_q, bl_d;
  logic [7:0]                  contrast_q, contrast_d;
  logic [7:0]                  glyph_num_q, glyph_num_d;
  logic [63:0]                 collect_q, collect_d;
  logic                        ev_have_q, ev_have_d;
  clci_pkg::ev_e               ev_kind_q, ev_kind_d;
  logic [7:0]                  ev_code_q, ev_code_d;
  logic                        clear_all;

  // scroll sweep
  logic [CntW-1:0]  sc_q;
  logic             wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;

  // addresses and ports
  logic [AddrW:0]   cur_addr_w, rd_addr_w;
  logic [AddrW-1:0] cur_addr, rd_addr, raddr, waddr;
  logic             re, we, rd_in_range, sweep_rd;
  logic [7:0]       wdata, stored;
  logic [2:0]       gidx;

  assign cur_addr_w  = (AddrW + 1)'(cur_row_q) * ColsA + (AddrW + 1)'(cur_col_q);
  assign cur_addr    = cur_addr_w[AddrW-1:0];
  assign rd_in_range = ({1'b0, rcol_q} < (ColW + 1)'(COLUMNS))
                     && ({1'b0, rrow_q} < 3'(ROWS));
  assign rd_addr_w   = (AddrW + 1)'(rrow_q) * ColsA + (AddrW + 1)'(rcol_q);
  assign rd_addr     = rd_in_range ? rd_addr_w[AddrW-1:0] : '0;
  assign sweep_rd    = ctl_i.scroll_step && (sc_q < SweepEnd);

  always_comb begin
    re    = 1'b1;
    raddr = cur_addr;
    priority if (ctl_i.rd_req) begin
      raddr = rd_addr;
    end else if (ctl_i.cell_req) begin
      raddr = cur_addr;
    end else if (sweep_rd) begin
      raddr = AddrW'(sc_q + ColsC);
    end else begin
      re = 1'b0;
    end
  end

  assign we    = ctl_i.cell_write || (ctl_i.scroll_step && wr_pend_q);
  assign waddr = ctl_i.cell_write ? cur_addr : wr_addr_q;
  assign wdata = ctl_i.cell_write ? byte_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // an entry never written since reset or clear reads as a space
  assign stored = rd_vld_q ? rdata_q : clci_pkg::CH_SPACE;
  assign gidx   = 3'(step_q - 4'd2);

  // command execution and cursor movement
  always_comb begin
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    in_cmd_d    = in_cmd_q;
    kind_d      = kind_q;
    step_d      = step_q;
    scroll_d    = scroll_q;
    bl_d        = bl_q;
    contrast_d  = contrast_q;
    glyph_num_d = glyph_num_q;
    collect_d   = collect_q;
    ev_have_d   = ev_have_q;
    ev_kind_d   = ev_kind_q;
    ev_code_d   = ev_code_q;
    clear_all   = 1'b0;

    if (ctl_i.exec) begin
      ev_have_d = 1'b0;
      priority if (!in_cmd_q) begin
        in_cmd_d = 1'b1;
        kind_d   = K_NONE;
        step_d   = 4'd0;
      end else if (step_q == 4'd0) begin
        in_cmd_d = 1'b0;
        kind_d   = K_NONE;
        unique case (byte_q)
          clci_pkg::CH_Q: scroll_d = 1'b1;
          clci_pkg::CH_R: scroll_d = 1'b0;
          clci_pkg::CH_B: begin
            bl_d      = 1'b1;
            in_cmd_d  = 1'b1;
            kind_d    = K_TIMEOUT;
            step_d    = 4'd1;
            ev_have_d = 1'b1;
            ev_kind_d = clci_pkg::EV_REDRAW;
            ev_code_d = 8'd0;
          end
          clci_pkg::CH_F: begin
            bl_d      = 1'b0;
            ev_have_d = 1'b1;
            ev_kind_d = clci_pkg::EV_REDRAW;
            ev_code_d = 8'd0;
          end
          clci_pkg::CH_X: begin
            clear_all = 1'b1;
            cur_col_d = '0;
            cur_row_d = '0;
            ev_have_d = 1'b1;
            ev_kind_d = clci_pkg::EV_REDRAW;
            ev_code_d = 8'd0;
          end
          clci_pkg::CH_P: begin
            in_cmd_d = 1'b1;
            kind_d   = K_CONTRAST;
            step_d   = 4'd1;
          end
          clci_pkg::CH_L: begin
            if (cur_col_q != '0) begin
              cur_col_d = cur_col_q - 1'b1;
            end else if (cur_row_q != '0) begin
              cur_col_d = ColIdxW'(COLUMNS - 1);
              cur_row_d = cur_row_q - 1'b1;
            end
          end
          clci_pkg::CH_M: begin
            if (cur_row_q < clci_pkg::CurRowW'(ROWS)) begin
              if ((ColIdxW + 1)'(cur_col_q) + 1'b1 < (ColIdxW + 1)'(COLUMNS)) begin
                cur_col_d = cur_col_q + 1'b1;
              end else begin
                cur_col_d = '0;
                cur_row_d = cur_row_q + 1'b1;
              end
            end
          end
          clci_pkg::CH_N: begin
            in_cmd_d  = 1'b1;
            kind_d    = K_GLYPH;
            step_d    = 4'd1;
            collect_d = '0;
          end
          clci_pkg::CH_G: begin
            in_cmd_d = 1'b1;
            kind_d   = K_POSITION;
            step_d   = 4'd1;
          end
          clci_pkg::CH_HASH: begin
            in_cmd_d = 1'b1;
            kind_d   = K_BIGNUM;
            step_d   = 4'd1;
          end
          default: ;
        endcase
        if (!in_cmd_d) begin
          step_d = 4'd0;
        end
      end else begin
        unique case (kind_q)
          K_TIMEOUT: begin
            in_cmd_d  = 1'b0;
            kind_d    = K_NONE;
            step_d    = 4'd0;
            ev_have_d = 1'b1;
            ev_kind_d = clci_pkg::EV_TIMEOUT;
            ev_code_d = byte_q;
          end
          K_CONTRAST: begin
            contrast_d = byte_q;
            in_cmd_d   = 1'b0;
            kind_d     = K_NONE;
            step_d     = 4'd0;
            ev_have_d  = 1'b1;
            ev_kind_d  = clci_pkg::EV_CONTRAST;
            ev_code_d  = byte_q;
          end
          K_POSITION: begin
            if (step_q == 4'd1) begin
              if (byte_q != 8'd0 && 9'(byte_q) <= 9'(COLUMNS)) begin
                cur_col_d = ColIdxW'(byte_q - 8'd1);
              end
              step_d = 4'd2;
            end else begin
              if (byte_q != 8'd0 && byte_q <= 8'(ROWS)) begin
                cur_row_d = clci_pkg::CurRowW'(byte_q - 8'd1);
              end
              in_cmd_d = 1'b0;
              kind_d   = K_NONE;
              step_d   = 4'd0;
            end
          end
          K_GLYPH: begin
            if (step_q == 4'd1) begin
              glyph_num_d = byte_q;
              step_d      = 4'd2;
            end else begin
              if (step_q <= 4'd9) begin
                collect_d[{gidx, 3'b000} +: 8] = byte_q;
              end
              if (step_q >= 4'd9) begin
                in_cmd_d  = 1'b0;
                kind_d    = K_NONE;
                step_d    = 4'd0;
                ev_have_d = 1'b1;
                ev_kind_d = clci_pkg::EV_GLYPH;
                ev_code_d = glyph_num_q;
              end else begin
                step_d = step_q + 4'd1;
              end
            end
          end
          K_BIGNUM: begin
            if (step_q == 4'd1) begin
              step_d = 4'd2;
            end else begin
              in_cmd_d = 1'b0;
              kind_d   = K_NONE;
              step_d   = 4'd0;
            end
          end
          default: begin
            in_cmd_d = 1'b0;
            kind_d   = K_NONE;
            step_d   = 4'd0;
          end
        endcase
      end
    end

    if (ctl_i.scroll_end) begin
      cur_row_d = clci_pkg::CurRowW'(ROWS - 1);
    end

    if (ctl_i.advance && cur_row_q < clci_pkg::CurRowW'(ROWS)) begin
      if ((ColIdxW + 1)'(cur_col_q) + 1'b1 < (ColIdxW + 1)'(COLUMNS)) begin
        cur_col_d = cur_col_q + 1'b1;
      end else begin
        cur_col_d = '0;
        cur_row_d = cur_row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      in_cmd_q    <= 1'b0;
      kind_q      <= K_NONE;
      step_q      <= 4'd0;
      scroll_q    <= 1'b0;
      bl_q        <= 1'b1;
      contrast_q  <= 8'd128;
      glyph_num_q <= 8'd0;
      collect_q   <= '0;
      ev_have_q   <= 1'b0;
      ev_kind_q   <= clci_pkg::EV_REDRAW;
      ev_code_q   <= 8'd0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      sc_q        <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      in_cmd_q    <= in_cmd_d;
      kind_q      <= kind_d;
      step_q      <= step_d;
      scroll_q    <= scroll_d;
      bl_q        <= bl_d;
      contrast_q  <= contrast_d;
      glyph_num_q <= glyph_num_d;
      collect_q   <= collect_d;
      ev_have_q   <= ev_have_d;
      ev_kind_q   <= ev_kind_d;
      ev_code_q   <= ev_code_d;

      if (re) begin
        rd_vld_q <= vld_q[raddr];
      end

      // valid bits: clear, scroll copy, last row blank, cell write
      if (clear_all) begin
        vld_q <= '0;
      end else if (ctl_i.scroll_end) begin
        for (int i = LastRow; i < Cells; i++) begin
          vld_q[i] <= 1'b0;
        end
      end else if (ctl_i.cell_write) begin
        vld_q[cur_addr] <= 1'b1;
      end else if (ctl_i.scroll_step && wr_pend_q) begin
        vld_q[wr_addr_q] <= rd_vld_q;
      end

      if (ctl_i.scroll_start) begin
        sc_q      <= '0;
        wr_pend_q <= 1'b0;
      end else if (ctl_i.scroll_step) begin
        wr_pend_q <= sweep_rd;
        if (sweep_rd) begin
          wr_addr_q <= sc_q[AddrW-1:0];
          sc_q      <= sc_q + 1'b1;
        end
      end

      if (ctl_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      mode_q <= mode_i;
      byte_q <= data_byte_i;
      rcol_q <= read_column_i;
      rrow_q <= read_row_i;
    end
    if (ctl_i.out_load) begin
      backlight_on_o   <= bl_q;
      contrast_level_o <= contrast_q;
      last_o           <= ctl_i.out_last;
      event_res_o      <= clci_pkg::EV_REDRAW;
      column_o         <= '0;
      row_o            <= '0;
      code_o           <= 8'd0;
      glyph_rows_o     <= '0;
      unique case (ctl_i.out_sel)
        clci_pkg::SEL_READ: begin
          event_res_o <= clci_pkg::EV_READ;
          column_o    <= rcol_q;
          row_o       <= rrow_q;
          code_o      <= rd_in_range ? stored : clci_pkg::CH_SPACE;
        end
        clci_pkg::SEL_REDRAW: begin
          event_res_o <= clci_pkg::EV_REDRAW;
        end
        clci_pkg::SEL_CELL: begin
          event_res_o <= clci_pkg::EV_CELL;
          column_o    <= ColW'(cur_col_q);
          row_o       <= cur_row_q[clci_pkg::RowW-1:0];
          code_o      <= byte_q;
        end
        clci_pkg::SEL_EVENT: begin
          event_res_o <= ev_kind_q;
          code_o      <= ev_code_q;
          if (ev_kind_q == clci_pkg::EV_GLYPH) begin
            glyph_rows_o <= collect_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.mode_read   = mode_q;
  assign sts_o.cmd_path    = in_cmd_q || (byte_q == clci_pkg::CH_CMD);
  assign sts_o.wrap        = (cur_row_q >= clci_pkg::CurRowW'(ROWS));
  assign sts_o.scroll_en   = scroll_q;
  assign sts_o.scroll_done = (sc_q == SweepEnd) && !wr_pend_q;
  assign sts_o.cell_change = (stored != byte_q) || (byte_q < clci_pkg::CH_GLYPH_LIMIT);
  assign sts_o.ev_have     = ev_have_q;
  assign sts_o.out_free    = !out_valid_o || !out_stall_i;

endmodule

FILE: rtl/core/clci_checker.sv
// port checks for the command interpreter, bound to the top level
`include "char_lcd_command_interpreter_core_macros.svh"

module clci_checker #(
  parameter int unsigned COLUMNS = 20
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        event_res_o,
  input logic [((COLUMNS >= 32) ? 6 : 5)-1:0] column_o,
  input logic [7:0]                        code_o,
  input logic [63:0]                       glyph_rows_o,
  input logic                              last_o
);

  `CLCI_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_o) && $stable(event_res_o))
  `CLCI_ASSERT(a_read_last, (out_valid_o && event_res_o == clci_pkg::EV_READ) |-> last_o)
  `CLCI_ASSERT(a_redraw_blank, (out_valid_o && event_res_o == clci_pkg::EV_REDRAW) |-> (code_o == 8'd0 && column_o == '0))
  `CLCI_ASSERT(a_glyph_only, (out_valid_o && event_res_o != clci_pkg::EV_GLYPH) |-> (glyph_rows_o == 64'd0))

endmodule

bind char_lcd_command_interpreter_core clci_checker #(.COLUMNS(COLUMNS)) u_clci_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_res_o  (event_res_o),
  .column_o     (column_o),
  .code_o       (code_o),
  .glyph_rows_o (glyph_rows_o),
  .last_o       (last_o)
);

FILE: tb/char_lcd_command_interpreter_checker.sv
// result predictor and scoreboard for the character lcd command interpreter
module char_lcd_command_interpreter_checker
  import clci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  read_column_i,
  input  logic [1:0]  read_row_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_res_i,
  input  logic [4:0]  column_i,
  input  logic [1:0]  row_i,
  input  logic [7:0]  code_i,
  input  logic [63:0] glyph_rows_i,
  input  logic        backlight_on_i,
  input  logic [7:0]  contrast_level_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  localparam int Cols = 20;
  localparam int Rows = 4;

  typedef enum logic [2:0] {
    K_NONE, K_TIMEOUT, K_POSITION, K_CONTRAST, K_GLYPH, K_BIGNUM
  } cmd_kind_e;

  typedef struct packed {
    ev_e         ev;
    logic [4:0]  col;
    logic [1:0]  row;
    logic [7:0]  code;
    logic [63:0] glyph;
    logic        backlight;
    logic [7:0]  contrast;
    logic        last;
  } lcd_event_t;

  lcd_event_t  lcd_event_q[$];
  logic [7:0]  text_mem[Cols*Rows];
  logic [4:0]  cur_col;
  logic [2:0]  cur_row;
  logic        in_cmd;
  cmd_kind_e   kind;
  logic [3:0]  step;
  logic        scroll_on;
  logic        backlight;
  logic [7:0]  contrast;
  logic [7:0]  timeout_val;
  logic [7:0]  glyph_num;
  logic [63:0] glyph_bits;

  task automatic note_event(ev_e ev, logic [4:0] c, logic [1:0] r, logic [7:0] code,
                            logic [63:0] g);
    lcd_event_t e;
    e = '{ev, c, r, code, g, backlight, contrast, 1'b0};
    lcd_event_q.push_back(e);
  endtask

  task automatic cursor_fwd();
    if (cur_row < Rows) begin
      if (cur_col + 1 < Cols) begin
        cur_col++;
      end else begin
        cur_col = 0;
        cur_row++;
      end
    end
  endtask

  task automatic end_cmd();
    in_cmd = 1'b0;
    kind   = K_NONE;
    step   = 0;
  endtask

  task automatic write_char(logic [7:0] ch);
    int idx;
    if (cur_row >= Rows) begin
      // pending wrap: drop the character or scroll up one row
      if (!scroll_on) return;
      for (int i = 0; i < (Rows-1)*Cols; i++) text_mem[i] = text_mem[i+Cols];
      for (int i = (Rows-1)*Cols; i < Rows*Cols; i++) text_mem[i] = CH_SPACE;
      cur_row = Rows - 1;
      note_event(EV_REDRAW, 0, 0, 0, 0);
    end
    idx = cur_row * Cols + cur_col;
    if (text_mem[idx] != ch || ch < CH_GLYPH_LIMIT) begin
      text_mem[idx] = ch;
      note_event(EV_CELL, cur_col, cur_row[1:0], ch, 0);
    end
    cursor_fwd();
  endtask

  task automatic opcode(logic [7:0] ch);
    end_cmd();
    case (ch)
      CH_Q: scroll_on = 1'b1;
      CH_R: scroll_on = 1'b0;
      CH_B: begin
        backlight = 1'b1;
        in_cmd = 1'b1; kind = K_TIMEOUT; step = 1;
        note_event(EV_REDRAW, 0, 0, 0, 0);
      end
      CH_F: begin
        backlight = 1'b0;
        note_event(EV_REDRAW, 0, 0, 0, 0);
      end
      CH_X: begin
        foreach (text_mem[i]) text_mem[i] = CH_SPACE;
        cur_col = 0;
        cur_row = 0;
        note_event(EV_REDRAW, 0, 0, 0, 0);
      end
      CH_P: begin
        in_cmd = 1'b1; kind = K_CONTRAST; step = 1;
      end
      CH_L: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_col = Cols - 1;
          cur_row--;
        end
      end
      CH_M: cursor_fwd();
      CH_N: begin
        in_cmd = 1'b1; kind = K_GLYPH; step = 1;
        glyph_bits = '0;
      end
      CH_G: begin
        in_cmd = 1'b1; kind = K_POSITION; step = 1;
      end
      CH_HASH: begin
        in_cmd = 1'b1; kind = K_BIGNUM; step = 1;
      end
      default: ;
    endcase
  endtask

  task automatic argument(logic [7:0] ch);
    case (kind)
      K_TIMEOUT: begin
        timeout_val = ch;
        end_cmd();
        note_event(EV_TIMEOUT, 0, 0, ch, 0);
      end
      K_CONTRAST: begin
        contrast = ch;
        end_cmd();
        note_event(EV_CONTRAST, 0, 0, ch, 0);
      end
      K_POSITION: begin
        // 1-based coordinates, out of range leaves that one alone
        if (step == 1) begin
          if (ch >= 1 && ch <= Cols) cur_col = 5'(ch - 1);
          step = 2;
        end else begin
          if (ch >= 1 && ch <= Rows) cur_row = 3'(ch - 1);
          end_cmd();
        end
      end
      K_GLYPH: begin
        if (step == 1) begin
          glyph_num = ch;
          step = 2;
        end else begin
          glyph_bits[(step-2)*8 +: 8] = ch;
          if (step >= 9) begin
            end_cmd();
            note_event(EV_GLYPH, 0, 0, glyph_num, glyph_bits);
          end else begin
            step++;
          end
        end
      end
      K_BIGNUM: begin
        if (step == 1) step = 2;
        else end_cmd();
      end
      default: end_cmd();
    endcase
  endtask

  task automatic predict_transfer(logic m, logic [7:0] ch, logic [4:0] rc, logic [1:0] rr);
    int depth0;
    depth0 = lcd_event_q.size();
    if (m) begin
      note_event(EV_READ, rc, rr, (rc < Cols) ? text_mem[rr*Cols + rc] : CH_SPACE, 0);
    end else if (!in_cmd) begin
      if (ch == CH_CMD) begin
        in_cmd = 1'b1; kind = K_NONE; step = 0;
      end else begin
        write_char(ch);
      end
    end else if (step == 0) begin
      opcode(ch);
    end else begin
      argument(ch);
    end
    if (lcd_event_q.size() > depth0) lcd_event_q[lcd_event_q.size()-1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcd_event_t e;
    if (!rst_ni) begin
      foreach (text_mem[i]) text_mem[i] = CH_SPACE;
      cur_col = 0; cur_row = 0;
      end_cmd();
      scroll_on = 1'b0; backlight = 1'b1; contrast = 8'd128;
      timeout_val = 0; glyph_num = 0; glyph_bits = '0;
      lcd_event_q.delete();
      fail_count_o  = 0;
      outstanding_o <= 0;
    end else begin
      // results first: they always belong to earlier transfers
      if (out_valid_i && !out_stall_i) begin
        if (lcd_event_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d code %0h",
                   $time, event_res_i, code_i);
          fail_count_o++;
        end else begin
          e = lcd_event_q.pop_front();
          check_field("event", e.ev, event_res_i);
          check_field("column", e.col, column_i);
          check_field("row", e.row, row_i);
          check_field("code", e.code, code_i);
          check_field("glyph_rows", e.glyph, glyph_rows_i);
          check_field("backlight", e.backlight, backlight_on_i);
          check_field("contrast", e.contrast, contrast_level_i);
          check_field("last", e.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_transfer(mode_i, data_byte_i, read_column_i, read_row_i);
      outstanding_o <= lcd_event_q.size();
    end
  end

endmodule

FILE: tb/char_lcd_command_interpreter_core_tb.sv
// stimulus, clocking and verdict for the character lcd command interpreter
module char_lcd_command_interpreter_core_tb;
  import clci_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic [4:0]  read_column_i = '0;
  logic [1:0]  read_row_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [4:0]  column_o;
  logic [1:0]  row_o;
  logic [7:0]  code_o;
  logic [63:0] glyph_rows_o;
  logic        backlight_on_o;
  logic [7:0]  contrast_level_o;
  logic        last_o;

  int fail_count;
  int outstanding;
  int idle_pct = 0;    // chance of a gap before each transfer
  int stall_pct = 0;   // chance of the receiver stalling in a cycle
  int sent = 0;
  int quiet_cycles = 0;

  char_lcd_command_interpreter_core dut (.*);

  char_lcd_command_interpreter_checker scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .data_byte_i,
    .read_column_i, .read_row_i, .out_valid_i(out_valid_o), .out_stall_i,
    .event_res_i(event_res_o), .column_i(column_o), .row_i(row_o), .code_i(code_o),
    .glyph_rows_i(glyph_rows_o), .backlight_on_i(backlight_on_o),
    .contrast_level_i(contrast_level_o), .last_i(last_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // watchdog: ends a run that stops moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one transfer; valid stays high between back-to-back transfers
  task automatic send(logic m, logic [7:0] b, logic [4:0] c, logic [1:0] r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    data_byte_i   <= b;
    read_column_i <= c;
    read_row_i    <= r;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic host_byte(logic [7:0] b);
    send(1'b0, b, 5'($urandom), 2'($urandom));
  endtask

  task automatic refresh_read(logic [4:0] c, logic [1:0] r);
    send(1'b1, 8'($urandom), c, r);
  endtask

  task automatic command(logic [7:0] op);
    host_byte(CH_CMD);
    host_byte(op);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // one random host sequence: a character, a refresh read, noise or a command with random content
  task automatic random_sequence();
    int k;
    k = $urandom_range(99);
    if (k < 35) begin
      host_byte(($urandom_range(9) < 3) ? 8'($urandom_range(7)) : 8'($urandom_range(253)));
    end else if (k < 45) begin
      refresh_read(5'($urandom_range(31)), 2'($urandom));
    end else if (k < 50) begin
      host_byte(8'($urandom));   // noise, may itself open a command
    end else begin
      case ($urandom_range(12))
        0:  command(CH_Q);
        1:  command(CH_R);
        2:  begin command(CH_B); host_byte(8'($urandom)); end
        3:  command(CH_F);
        4:  command(CH_X);
        5:  begin command(CH_P); host_byte(8'($urandom)); end
        6:  command(CH_L);
        7:  command(CH_M);
        8:  begin
          command(CH_N);
          repeat (9) host_byte(8'($urandom));
        end
        9:  begin
          command(CH_G);
          host_byte(8'($urandom_range(21)));
          host_byte(8'($urandom_range(5)));
        end
        10: begin
          // park near the end of the last row so wraps and scrolls happen often
          command(CH_G);
          host_byte(8'($urandom_range(17, 20)));
          host_byte(8'd4);
        end
        11: begin command(CH_HASH); host_byte(8'($urandom)); host_byte(8'($urandom)); end
        default: command(8'($urandom));
      endcase
    end
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads at both ends, low codes, unchanged cells, wrap and scroll
    refresh_read(5'd0, 2'd0);
    refresh_read(5'd31, 2'd3);
    host_byte(8'd0);
    host_byte(8'd0);
    command(CH_L);
    host_byte(8'd65);
    command(CH_L);
    host_byte(8'd65);             // same code, no report
    command(CH_G); host_byte(8'd20); host_byte(8'd4);
    host_byte(8'd255);            // last cell, wrap now pending
    host_byte(8'd97);             // dropped with scrolling off
    command(CH_L);                // back from the wrap to the last cell
    command(CH_M);
    command(CH_M);                // no move while the wrap is pending
    command(CH_G); host_byte(8'd3); host_byte(8'd9);
    command(CH_Q);
    host_byte(8'd98);             // scroll then write
    command(CH_G); host_byte(8'd0); host_byte(8'd0);
    command(CH_B); host_byte(8'd255);
    command(CH_F);
    command(CH_P); host_byte(8'd0);
    command(CH_N);
    host_byte(8'd7);
    for (int i = 0; i < 8; i++) host_byte(8'(8'h11 * i) ^ 8'hA5);
    command(CH_HASH); host_byte(8'd1); host_byte(8'd2);
    command(8'd75);               // unknown opcode
    refresh_read(5'd19, 2'd3);
    command(CH_X);
    command(CH_R);
    drain();

    // random phases with different idling and receiver stalls
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        3: begin idle_pct = 37; stall_pct = 37; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      base = sent;
      while (sent - base < 65) random_sequence();
      drain();
    end

    stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
